// ===== design/sott_pkg.sv =====
package sott_pkg;

    // Port widths of the item fields
    localparam int OP_W       = 2;
    localparam int OFS_PORT_W = 32;
    localparam int SID_PORT_W = 16;
    localparam int STATUS_W   = 2;

    // Defaults for the top-level parameters
    localparam int MAX_SEGMENTS_DEF   = 64;
    localparam int OFFSET_BITS_DEF    = 32;
    localparam int SOURCE_ID_BITS_DEF = 16;

    // Operation codes
    localparam logic [OP_W-1:0] OP_APPEND_MAPPED   = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND_UNMAPPED = 2'd1;
    localparam logic [OP_W-1:0] OP_FLAT_TO_SRC     = 2'd2;
    localparam logic [OP_W-1:0] OP_SRC_TO_FLAT     = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd3;

endpackage

// ===== design/sott_seg_mem.sv =====
module sott_seg_mem #(
    parameter int DEPTH  = sott_pkg::MAX_SEGMENTS_DEF,
    parameter int DATA_W = 3 * sott_pkg::OFFSET_BITS_DEF + sott_pkg::SOURCE_ID_BITS_DEF,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Write one segment record
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read, data is valid in the cycle after rd_en
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/segment_offset_translation_table.sv =====
// Channel | Direction | Ports
// s_      | in        | s_valid, s_ready, s_op, s_run_length, s_flat_offset, s_source_id,
//         |           | s_source_offset
// m_      | out       | m_valid, m_ready, m_status, m_found_source_id,
//         |           | m_found_source_offset, m_found_flat_offset
//
// An append goes from accept straight to the finish state. A lookup's length is set by the
// single read port of the segment memory, which the scan walks one entry per cycle in
// insertion order, stopping at the first match.
// One item is in flight at a time; s_ready is high only while idle.
// A finished result waits in the m_ register while the next item may already be taken.
// Reset clears the segment count and total length; the memory gets no clearing pass.
module segment_offset_translation_table #(
    parameter int MAX_SEGMENTS   = sott_pkg::MAX_SEGMENTS_DEF,
    parameter int OFFSET_BITS    = sott_pkg::OFFSET_BITS_DEF,
    parameter int SOURCE_ID_BITS = sott_pkg::SOURCE_ID_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [sott_pkg::OP_W-1:0]         s_op,
    input  logic [sott_pkg::OFS_PORT_W-1:0]   s_run_length,
    input  logic [sott_pkg::OFS_PORT_W-1:0]   s_flat_offset,
    input  logic [sott_pkg::SID_PORT_W-1:0]   s_source_id,
    input  logic [sott_pkg::OFS_PORT_W-1:0]   s_source_offset,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [sott_pkg::STATUS_W-1:0]     m_status,
    output logic [sott_pkg::SID_PORT_W-1:0]   m_found_source_id,
    output logic [sott_pkg::OFS_PORT_W-1:0]   m_found_source_offset,
    output logic [sott_pkg::OFS_PORT_W-1:0]   m_found_flat_offset
);

    localparam int OW  = OFFSET_BITS;
    localparam int SW  = SOURCE_ID_BITS;
    localparam int OPW = sott_pkg::OFS_PORT_W;
    localparam int SPW = sott_pkg::SID_PORT_W;
    localparam int IW  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CW  = $clog2(MAX_SEGMENTS + 1);
    localparam int EW  = 3 * OW + SW;

    localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_SEGMENTS);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0]                    state_reg, state_next;
    logic [CW-1:0]                 count_reg, count_next;
    logic [OW-1:0]                 total_reg, total_next;
    logic [sott_pkg::OP_W-1:0]     op_reg, op_next;
    logic [OW-1:0]                 flat_reg, flat_next;
    logic [SW-1:0]                 sid_reg, sid_next;
    logic [OW-1:0]                 soff_reg, soff_next;
    logic [CW-1:0]                 issue_reg, issue_next;
    logic                          cmp_vld_reg, cmp_vld_next;
    logic [sott_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic [SW-1:0]                 res_sid_reg, res_sid_next;
    logic [OW-1:0]                 res_soff_reg, res_soff_next;
    logic [OW-1:0]                 res_flat_reg, res_flat_next;
    logic                          m_valid_reg, m_valid_next;
    logic [sott_pkg::STATUS_W-1:0] m_status_reg, m_status_next;
    logic [SW-1:0]                 m_sid_reg, m_sid_next;
    logic [OW-1:0]                 m_soff_reg, m_soff_next;
    logic [OW-1:0]                 m_flat_reg, m_flat_next;

    logic          accept;
    logic [OW-1:0] in_len, in_flat, in_soff;
    logic [SW-1:0] in_sid;
    logic          len_overflow;

    logic          wr_en, rd_en;
    logic [IW-1:0] wr_addr, rd_addr;
    logic [EW-1:0] wr_data, rd_data;

    logic [OW-1:0] e_flat, e_len, e_src;
    logic [SW-1:0] e_sid;
    logic [OW-1:0] d_fwd, d_rev;
    logic          hit_fwd, hit_rev, hit, issue;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == S_IDLE);

    // Resize the port fields to the working offset and id widths
    assign in_len  = OW'(s_run_length);
    assign in_flat = OW'(s_flat_offset);
    assign in_soff = OW'(s_source_offset);
    assign in_sid  = SW'(s_source_id);

    // Room left below the top of the offset range is the complement of the total
    assign len_overflow = (in_len > ~total_reg);

    // Segment record: {flat start, length, source start, source id}
    assign e_sid  = rd_data[SW-1:0];
    assign e_src  = rd_data[SW +: OW];
    assign e_len  = rd_data[SW + OW +: OW];
    assign e_flat = rd_data[SW + 2 * OW +: OW];

    // Containment tests on the entry read last cycle
    assign d_fwd   = flat_reg - e_flat;
    assign d_rev   = soff_reg - e_src;
    assign hit_fwd = (flat_reg >= e_flat) && (d_fwd < e_len);
    assign hit_rev = (sid_reg == e_sid) && (soff_reg >= e_src) && (d_rev < e_len);
    assign hit     = (op_reg == sott_pkg::OP_FLAT_TO_SRC) ? hit_fwd : hit_rev;

    assign issue   = (state_reg == S_SCAN) && (issue_reg < count_reg);
    assign rd_en   = issue;
    assign rd_addr = issue_reg[IW-1:0];

    // Mapped append writes the next free entry; it never overlaps a scan read
    assign wr_en   = accept && (s_op == sott_pkg::OP_APPEND_MAPPED) && (in_len != '0)
                     && (count_reg < COUNT_MAX) && !len_overflow;
    assign wr_addr = count_reg[IW-1:0];
    assign wr_data = {total_reg, in_len, in_soff, in_sid};

    sott_seg_mem #(
        .DEPTH  (MAX_SEGMENTS),
        .DATA_W (EW),
        .ADDR_W (IW)
    ) u_seg_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Control and datapath next values
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        total_next      = total_reg;
        op_next         = op_reg;
        flat_next       = flat_reg;
        sid_next        = sid_reg;
        soff_next       = soff_reg;
        issue_next      = issue_reg;
        cmp_vld_next    = 1'b0;
        res_status_next = res_status_reg;
        res_sid_next    = res_sid_reg;
        res_soff_next   = res_soff_reg;
        res_flat_next   = res_flat_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_sid_next      = m_sid_reg;
        m_soff_next     = m_soff_reg;
        m_flat_next     = m_flat_reg;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    op_next         = s_op;
                    flat_next       = in_flat;
                    sid_next        = in_sid;
                    soff_next       = in_soff;
                    res_status_next = sott_pkg::ST_OK;
                    res_sid_next    = '0;
                    res_soff_next   = '0;
                    res_flat_next   = '0;
                    issue_next      = '0;
                    state_next      = S_FINISH;
                    case (s_op)
                        sott_pkg::OP_APPEND_MAPPED: begin
                            if (in_len == '0) begin
                                res_status_next = sott_pkg::ST_OK;
                            end else if (count_reg >= COUNT_MAX) begin
                                res_status_next = sott_pkg::ST_FULL;
                            end else if (len_overflow) begin
                                res_status_next = sott_pkg::ST_OVERFLOW;
                            end else begin
                                count_next = count_reg + 1'b1;
                                total_next = total_reg + in_len;
                            end
                        end
                        sott_pkg::OP_APPEND_UNMAPPED: begin
                            if (len_overflow) begin
                                res_status_next = sott_pkg::ST_OVERFLOW;
                            end else begin
                                total_next = total_reg + in_len;
                            end
                        end
                        default: begin
                            state_next = S_SCAN;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // Issue one read per cycle, test the entry that came back
                if (issue) begin
                    issue_next   = issue_reg + 1'b1;
                    cmp_vld_next = 1'b1;
                end
                if (cmp_vld_reg && hit) begin
                    res_status_next = sott_pkg::ST_OK;
                    if (op_reg == sott_pkg::OP_FLAT_TO_SRC) begin
                        res_sid_next  = e_sid;
                        res_soff_next = e_src + d_fwd;
                    end else begin
                        res_flat_next = e_flat + d_rev;
                    end
                    cmp_vld_next = 1'b0;
                    state_next   = S_FINISH;
                end else if (!issue) begin
                    res_status_next = sott_pkg::ST_NOT_FOUND;
                    state_next      = S_FINISH;
                end
            end
            S_FINISH: begin
                // Hand the result to the output register once it is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_sid_next    = res_sid_reg;
                    m_soff_next   = res_soff_reg;
                    m_flat_next   = res_flat_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            total_reg   <= '0;
            cmp_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            total_reg   <= total_next;
            cmp_vld_reg <= cmp_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        flat_reg       <= flat_next;
        sid_reg        <= sid_next;
        soff_reg       <= soff_next;
        issue_reg      <= issue_next;
        res_status_reg <= res_status_next;
        res_sid_reg    <= res_sid_next;
        res_soff_reg   <= res_soff_next;
        res_flat_reg   <= res_flat_next;
        m_status_reg   <= m_status_next;
        m_sid_reg      <= m_sid_next;
        m_soff_reg     <= m_soff_next;
        m_flat_reg     <= m_flat_next;
    end

    assign m_valid               = m_valid_reg;
    assign m_status              = m_status_reg;
    assign m_found_source_id     = SPW'(m_sid_reg);
    assign m_found_source_offset = OPW'(m_soff_reg);
    assign m_found_flat_offset   = OPW'(m_flat_reg);

    // Segment count never passes the table size
    assert property (@(posedge aclk) disable iff (!aresetn) count_reg <= COUNT_MAX)
        else $error("segment count above table size");

    // Total length only grows, it never wraps
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (total_reg >= $past(total_reg)))
        else $error("total length decreased");

    // Segment count changes only after an accepted mapped append
    assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && (count_reg != $past(count_reg)))
        |-> $past(accept && (s_op == sott_pkg::OP_APPEND_MAPPED)))
        else $error("segment count changed without a mapped append");

endmodule
